### sv/sare_pkg.sv
// ----------------------------------------------------------------------------
// sare_pkg
// Shared types, widths and constants of the sample adaptive rice encoder.
// ----------------------------------------------------------------------------
package sare_pkg;

    localparam int NUM_BANDS  = 256;
    localparam int BAND_W     = $clog2(NUM_BANDS);

    localparam int SAMPLE_W   = 32;
    localparam int BAND_IN_W  = 8;
    localparam int CW_W       = 64;
    localparam int LEN_W      = 7;
    localparam int CNT_W      = 11;
    localparam int ACC_W      = 44;
    localparam int K_W        = 5;
    localparam int K_MAX      = 30;

    localparam int D_W        = 6;
    localparam int UMAX_W     = 6;
    localparam int IEXP_W     = 4;
    localparam int KC_W       = 5;
    localparam int YSTAR_W    = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_RANGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNARY_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT_EXP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_INIT_CONST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESCALE_EXP    = 3'd4;

    // reset values and legal ranges
    localparam logic [D_W-1:0]     D_RESET     = 6'd16;
    localparam logic [D_W-1:0]     D_MIN       = 6'd2;
    localparam logic [D_W-1:0]     D_MAX       = 6'd32;
    localparam logic [UMAX_W-1:0]  UMAX_RESET  = 6'd18;
    localparam logic [UMAX_W-1:0]  UMAX_MIN    = 6'd8;
    localparam logic [UMAX_W-1:0]  UMAX_MAX    = 6'd32;
    localparam logic [IEXP_W-1:0]  IEXP_RESET  = 4'd1;
    localparam logic [IEXP_W-1:0]  IEXP_MIN    = 4'd1;
    localparam logic [IEXP_W-1:0]  IEXP_MAX    = 4'd8;
    localparam logic [KC_W-1:0]    KC_RESET    = 5'd3;
    localparam logic [KC_W-1:0]    KC_MAX      = 5'd30;
    localparam logic [YSTAR_W-1:0] YSTAR_RESET = 4'd6;
    localparam logic [YSTAR_W-1:0] YSTAR_MIN   = 4'd4;
    localparam logic [YSTAR_W-1:0] YSTAR_MAX   = 4'd11;

    // statistics arithmetic constants
    localparam int MEAN_MUL       = 49;
    localparam int MEAN_SHIFT     = 7;
    localparam int ACC_INIT_MUL   = 3;
    localparam int ACC_INIT_SHIFT = 6;

    // depth of the two small queues
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [D_W-1:0]     d;
        logic [UMAX_W-1:0]  umax;
        logic [IEXP_W-1:0]  iexp;
        logic [KC_W-1:0]    kc;
        logic [YSTAR_W-1:0] ystar;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [BAND_W-1:0]   band;
        logic                first;
    } item_t;

    typedef struct packed {
        logic [CW_W-1:0]  codeword;
        logic [LEN_W-1:0] code_length;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [ACC_W-1:0] acc;
    } stats_t;

    function automatic logic [CFG_DATA_W-1:0] clamp_u(
        input logic [CFG_DATA_W-1:0] v,
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi
    );
        logic [CFG_DATA_W-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

### sv/sare_front.sv
// ----------------------------------------------------------------------------
// sare_front
// Accepts input words, trims samples to the bit depth and queues them.
// ----------------------------------------------------------------------------
module sare_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sare_pkg::cfg_t                  cfg,
    input  logic                            push,
    output logic                            full,
    input  logic [sare_pkg::SAMPLE_W-1:0]   sample,
    input  logic [sare_pkg::BAND_IN_W-1:0]  band,
    input  logic                            first_in_band,
    output sare_pkg::item_t                 item,
    input  logic                            take,
    output logic                            item_valid
);
    import sare_pkg::*;

    item_t               entries [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]    count_reg, count_next;
    logic                wr_en;
    logic                rd_en;
    logic [SAMPLE_W-1:0] smask;
    item_t               in_item;

    assign full       = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign item_valid = (count_reg != '0);
    assign wr_en      = push && !full;
    assign rd_en      = take && item_valid;
    assign item       = entries[rd_ptr_reg];

    // d is 2..32, so the shift is 0..30
    assign smask = {SAMPLE_W{1'b1}} >> (D_MAX - cfg.d);

    always_comb
    begin
        in_item.sample = sample & smask;
        in_item.band   = band[BAND_W-1:0];
        in_item.first  = first_in_band;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### sv/sare_res_queue.sv
// ----------------------------------------------------------------------------
// sare_res_queue
// Short result queue between the coder and the output port.
// ----------------------------------------------------------------------------
module sare_res_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  sare_pkg::result_t  din,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output sare_pkg::result_t  dout
);
    import sare_pkg::*;

    result_t             entries [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]    count_reg, count_next;
    logic                do_wr;
    logic                do_rd;

    assign full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = pop && !empty;
    assign dout  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= din;
        end
    end

endmodule

### sv/sare_back.sv
// ----------------------------------------------------------------------------
// sare_back
// Per-band statistics memory, k selection, codeword build and update.
// ----------------------------------------------------------------------------
module sare_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sare_pkg::cfg_t     cfg,
    input  sare_pkg::item_t    item,
    input  logic               item_valid,
    output logic               item_take,
    input  logic               res_full,
    output logic               res_push,
    output sare_pkg::result_t  res
);
    import sare_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_CMP  = 5'b00100,
        S_KSEL = 5'b01000,
        S_CODE = 5'b10000
    } state_t;

    localparam int SUM_W  = ACC_W + 1;
    localparam int INIT_W = 47;

    state_t              state_reg, state_next;
    item_t               item_reg;
    stats_t              rd_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [K_MAX-1:0]    ge_reg, ge_next;
    logic [K_W-1:0]      k_reg, k_next;
    stats_t              mem [NUM_BANDS];

    logic                take;
    logic                mem_we;
    stats_t              new_stats;
    logic [SAMPLE_W-1:0] u;
    logic [SAMPLE_W-1:0] low_bits;
    logic [CNT_W:0]      cnt_limit;
    logic [CNT_W:0]      cnt_inc;
    logic [SUM_W-1:0]    acc_round;
    logic [INIT_W-1:0]   init_base;
    logic [INIT_W-1:0]   init_scaled;

    assign take      = (state_reg == S_IDLE) && item_valid;
    assign item_take = take;

    // mean estimate: accumulator plus floor(49 * counter / 128)
    always_comb
    begin
        sum_next = {1'b0, rd_reg.acc}
                 + SUM_W'((18'(rd_reg.cnt) * 18'(MEAN_MUL)) >> MEAN_SHIFT);
    end

    // thresholds are monotonic in j, so the passing ones form a prefix
    always_comb
    begin
        for (int j = 1; j <= K_MAX; j++)
        begin
            ge_next[j-1] = ((SUM_W'(item_reg.first ? '0 : rd_reg.cnt) << j) <= sum_reg)
                        && ((7'(j) + 7'd2) <= 7'(cfg.d));
        end
    end

    assign k_next = K_W'($countones(ge_reg));

    // codeword, length and new statistics
    always_comb
    begin
        u           = item_reg.sample >> k_reg;
        low_bits    = item_reg.sample & ~({SAMPLE_W{1'b1}} << k_reg);
        cnt_limit   = ((CNT_W+1)'(1) << cfg.ystar) - (CNT_W+1)'(1);
        cnt_inc     = {1'b0, rd_reg.cnt} + (CNT_W+1)'(1);
        acc_round   = {1'b0, rd_reg.acc} + SUM_W'(item_reg.sample) + SUM_W'(1);
        init_base   = (INIT_W'(ACC_INIT_MUL) << (6'(cfg.kc) + 6'(ACC_INIT_SHIFT)))
                    - INIT_W'(MEAN_MUL);
        init_scaled = (init_base << cfg.iexp) >> MEAN_SHIFT;

        res = '0;
        new_stats = rd_reg;
        if (item_reg.first)
        begin
            res.codeword    = CW_W'(item_reg.sample);
            res.code_length = LEN_W'(cfg.d);
            new_stats.cnt   = CNT_W'(1) << cfg.iexp;
            new_stats.acc   = ACC_W'(init_scaled);
        end
        else
        begin
            if (u < SAMPLE_W'(cfg.umax))
            begin
                res.codeword    = CW_W'((SAMPLE_W'(1) << k_reg) | low_bits);
                res.code_length = LEN_W'(u[UMAX_W-1:0]) + LEN_W'(1) + LEN_W'(k_reg);
            end
            else
            begin
                // escape: unary limit of zeros then the raw sample
                res.codeword    = CW_W'(item_reg.sample);
                res.code_length = LEN_W'(cfg.umax) + LEN_W'(cfg.d);
            end
            if ({1'b0, rd_reg.cnt} < cnt_limit)
            begin
                new_stats.acc = ACC_W'({1'b0, rd_reg.acc} + SUM_W'(item_reg.sample));
                new_stats.cnt = cnt_inc[CNT_W-1:0];
            end
            else
            begin
                new_stats.acc = acc_round[SUM_W-1:1];
                new_stats.cnt = cnt_inc[CNT_W:1];
            end
        end
    end

    assign res_push = (state_reg == S_CODE) && !res_full;
    assign mem_we   = res_push;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = item.first ? S_CODE : S_SUM;
                end
            end
            S_SUM:  state_next = S_CMP;
            S_CMP:  state_next = S_KSEL;
            S_KSEL: state_next = S_CODE;
            S_CODE:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == S_CMP)
        begin
            ge_reg <= ge_next;
        end
        if (state_reg == S_KSEL)
        begin
            k_reg <= k_next;
        end
    end

    // statistics memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[item_reg.band] <= new_stats;
        end
        if (take)
        begin
            rd_reg <= mem[item.band];
        end
    end

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CODE && !item_reg.first) |-> (7'(k_reg) + 7'd2 <= 7'(cfg.d)))
        else $error("k above bit depth minus two");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res.code_length != '0))
        else $error("zero length codeword");

    a_first_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.first) |=> (state_reg == S_CODE))
        else $error("first sample of band did not go straight to coding");

    a_push_frees: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (state_reg == S_IDLE))
        else $error("coder stayed busy after result push");

endmodule

### sv/sample_adaptive_rice_encoder_top.sv
// ----------------------------------------------------------------------------
// sample_adaptive_rice_encoder_top
// Sample adaptive rice entropy coder with per-band statistics.
// ----------------------------------------------------------------------------
// Input channel: a word (sample, band, first_in_band) is taken at a clock edge
// with push high and full low. A two-word front queue trims the sample to the
// bit depth and holds it until the coder is free.
// Result channel: while empty is low, codeword and code_length show the oldest
// result; it is taken at an edge with pop high. A two-word result queue lets
// the coder finish the next word while a result waits.
// Sequencing: the coder handles one word at a time. A first-of-band word goes
// through memory read and code; any other word goes through memory read,
// mean sum, threshold compares, k count, code and write-back. The sequence is
// set by the read-modify-write of the statistics memory.
// Reset clears queues and the sequencer and loads the register defaults; the
// statistics memory is not cleared, each band must start with a first word.
// When the receiver stalls, the result queue fills, the coder holds its
// result, then the front queue fills and full goes high.
// Configuration: cfg_write_en with cfg_index and cfg_data, written while idle.
// ----------------------------------------------------------------------------
module sample_adaptive_rice_encoder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [sare_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sare_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [sare_pkg::SAMPLE_W-1:0]     sample,
    input  logic [sare_pkg::BAND_IN_W-1:0]    band,
    input  logic                              first_in_band,
    output logic                              empty,
    input  logic                              pop,
    output logic [sare_pkg::CW_W-1:0]         codeword,
    output logic [sare_pkg::LEN_W-1:0]        code_length
);
    import sare_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    item_t   item;
    logic    item_take;
    logic    item_valid;
    logic    res_full;
    logic    res_push;
    result_t res_in;
    result_t res_out;

    // registers hold their clamped values
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_DYNAMIC_RANGE:
                    cfg_next.d = clamp_u(cfg_data, D_MIN, D_MAX);
                REG_UNARY_LIMIT:
                    cfg_next.umax = clamp_u(cfg_data, UMAX_MIN, UMAX_MAX);
                REG_INIT_COUNT_EXP:
                    cfg_next.iexp = IEXP_W'(clamp_u(CFG_DATA_W'(cfg_data[IEXP_W-1:0]),
                                                    CFG_DATA_W'(IEXP_MIN),
                                                    CFG_DATA_W'(IEXP_MAX)));
                REG_ACC_INIT_CONST:
                    cfg_next.kc = KC_W'(clamp_u(CFG_DATA_W'(cfg_data[KC_W-1:0]),
                                                '0, CFG_DATA_W'(KC_MAX)));
                REG_RESCALE_EXP:
                    cfg_next.ystar = YSTAR_W'(clamp_u(CFG_DATA_W'(cfg_data[YSTAR_W-1:0]),
                                                      CFG_DATA_W'(YSTAR_MIN),
                                                      CFG_DATA_W'(YSTAR_MAX)));
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.d     <= D_RESET;
            cfg_reg.umax  <= UMAX_RESET;
            cfg_reg.iexp  <= IEXP_RESET;
            cfg_reg.kc    <= KC_RESET;
            cfg_reg.ystar <= YSTAR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sare_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .push          (push),
        .full          (full),
        .sample        (sample),
        .band          (band),
        .first_in_band (first_in_band),
        .item          (item),
        .take          (item_take),
        .item_valid    (item_valid)
    );

    sare_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    sare_res_queue u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .empty (empty),
        .dout  (res_out)
    );

    assign codeword    = res_out.codeword;
    assign code_length = res_out.code_length;

endmodule
